// ===== rtl/ttok_pkg.sv =====
`timescale 1ns / 1ps

package ttok_pkg;

  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_PUNCT = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       has_byte;
    logic       token_last;
    logic [1:0] token_kind;
    logic       text_end;
  } result_t;

  localparam result_t END_RESULT = '{
    token_byte: 8'h00, has_byte: 1'b0, token_last: 1'b0,
    token_kind: KIND_WORD, text_end: 1'b1
  };

  function automatic logic is_word_break(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_RPAREN) ||
           (b == CH_LPAREN) || (b == CH_APOS);
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    return is_word_break(b) || (b == CH_COLON);
  endfunction

endpackage

// ===== rtl/text_tokenizer_stream_unit.sv =====
`timescale 1ns / 1ps

// Streaming tokenizer: one text byte per request in, at most one token
// character per result out, with last-character mark, token kind and an
// end-of-text result after a zero byte. Each byte is decoded combinationally
// into a two-entry result buffer, so with the output side ready a byte is
// taken every cycle; a byte with two results (word end plus punctuation, or
// a token close plus end of text) holds off the next byte while the buffer
// drains; input is taken only when the buffer empties with this cycle's pop.
module text_tokenizer_stream_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] token_byte,
  output logic       has_byte,
  output logic       token_last,
  output logic [1:0] token_kind,
  output logic       text_end
);
  import ttok_pkg::*;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_QEMPTY  = 3'd3,
    MODE_QHELD   = 3'd4,
    MODE_WORD    = 3'd5
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] held, held_next;
  result_t    q0, q1;
  logic [1:0] count;

  result_t    r0, r1;
  logic [1:0] nres;
  logic       do_word;
  logic       pop, accept;
  logic [1:0] cnt_after;

  always_comb begin
    mode_next = mode;
    held_next = held;
    nres      = 2'd0;
    r0        = '0;
    r1        = '0;
    do_word   = 1'b0;
    unique case (mode)
      MODE_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_next = MODE_COMMENT;
        end else begin
          do_word = 1'b1;
        end
      end
      MODE_WORD: begin
        do_word = 1'b1;
      end
      MODE_COMMENT: begin
        if (text_byte == CH_NUL) begin
          r0        = END_RESULT;
          nres      = 2'd1;
          mode_next = MODE_BETWEEN;
          held_next = 8'h00;
        end else if (text_byte == CH_NL) begin
          mode_next = MODE_BETWEEN;
        end
      end
      MODE_QEMPTY, MODE_QHELD: begin
        if (text_byte == CH_DQUOTE || text_byte == CH_NUL) begin
          r0.token_byte = (mode == MODE_QHELD) ? held : 8'h00;
          r0.has_byte   = (mode == MODE_QHELD);
          r0.token_last = 1'b1;
          r0.token_kind = KIND_QUOTE;
          nres          = 2'd1;
          mode_next     = MODE_BETWEEN;
          if (text_byte == CH_NUL) begin
            r1        = END_RESULT;
            nres      = 2'd2;
            held_next = 8'h00;
          end
        end else begin
          if (mode == MODE_QHELD) begin
            r0.token_byte = held;
            r0.has_byte   = 1'b1;
            r0.token_kind = KIND_QUOTE;
            nres          = 2'd1;
          end
          held_next = text_byte;
          mode_next = MODE_QHELD;
        end
      end
      default: begin
        mode_next = MODE_BETWEEN;
        if (text_byte == CH_NUL) begin
          r0        = END_RESULT;
          nres      = 2'd1;
          held_next = 8'h00;
        end else if (text_byte <= CH_SPACE) begin
          mode_next = MODE_BETWEEN;
        end else if (text_byte == CH_SLASH) begin
          mode_next = MODE_SLASH;
          held_next = text_byte;
        end else if (text_byte == CH_DQUOTE) begin
          mode_next = MODE_QEMPTY;
        end else if (is_single(text_byte)) begin
          r0.token_byte = text_byte;
          r0.has_byte   = 1'b1;
          r0.token_last = 1'b1;
          r0.token_kind = KIND_PUNCT;
          nres          = 2'd1;
        end else begin
          mode_next = MODE_WORD;
          held_next = text_byte;
        end
      end
    endcase

    if (do_word) begin
      r0.token_byte = held;
      r0.has_byte   = 1'b1;
      r0.token_kind = KIND_WORD;
      nres          = 2'd1;
      if (text_byte == CH_NUL) begin
        r0.token_last = 1'b1;
        r1            = END_RESULT;
        nres          = 2'd2;
        mode_next     = MODE_BETWEEN;
        held_next     = 8'h00;
      end else if (text_byte <= CH_SPACE) begin
        r0.token_last = 1'b1;
        mode_next     = MODE_BETWEEN;
      end else if (is_word_break(text_byte)) begin
        r0.token_last = 1'b1;
        r1.token_byte = text_byte;
        r1.has_byte   = 1'b1;
        r1.token_last = 1'b1;
        r1.token_kind = KIND_PUNCT;
        nres          = 2'd2;
        mode_next     = MODE_BETWEEN;
      end else begin
        held_next = text_byte;
        mode_next = MODE_WORD;
      end
    end
  end

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign cnt_after = count - {1'b0, pop};
  assign in_ready  = (cnt_after == 2'd0);
  assign accept    = in_valid && in_ready;

  assign token_byte = q0.token_byte;
  assign has_byte   = q0.has_byte;
  assign token_last = q0.token_last;
  assign token_kind = q0.token_kind;
  assign text_end   = q0.text_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_BETWEEN;
      held  <= 8'h00;
      count <= 2'd0;
    end else begin
      if (accept) begin
        mode  <= mode_next;
        held  <= held_next;
        q0    <= r0;
        q1    <= r1;
        count <= nres;
      end else begin
        if (pop) begin
          q0 <= q1;
        end
        count <= cnt_after;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    accept |-> (count == 2'd0 || (count == 2'd1 && out_ready)))
    else $error("request accepted into a non-draining buffer");

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> !has_byte && !token_last && token_kind == KIND_WORD)
    else $error("end result carries token data");

  a_empty_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte && !text_end |-> token_last && token_kind == KIND_QUOTE)
    else $error("byteless result is not an empty quoted token");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && text_byte == CH_NUL |=> mode == MODE_BETWEEN && held == 8'h00)
    else $error("end of text did not return to between tokens");

endmodule
